>>> rtl/sidmap_pkg.sv
// Shared constants, types and helpers for the serial frame channel mapper.
// No dependencies; the controller, datapath, top level and testbench import this package.
package sidmap_pkg;

  localparam int MAX_FRAME   = 16;
  localparam int CHANNELS    = 256;
  localparam int START_BYTES = 4;

  localparam int FL_W    = $clog2(MAX_FRAME + 1);
  localparam int FIDX_W  = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int CH_W    = $clog2(CHANNELS);
  localparam int CNT_W   = $clog2(CHANNELS + 1);
  localparam int KEY_W   = MAX_FRAME * 8;
  localparam int ENTRY_W = KEY_W + FL_W + 1;
  localparam int SB_N    = (START_BYTES < MAX_FRAME) ? START_BYTES : MAX_FRAME;

  localparam logic [7:0]  PRINT_LO   = 8'd32;
  localparam logic [7:0]  PRINT_HI   = 8'd126;
  localparam logic [7:0]  DOT_BYTE   = 8'h2E;
  localparam logic [15:0] HOLD_TIMED = 16'd50;

  localparam logic [31:0] START_PATTERN_RST = 32'h0000_0020;
  localparam logic [2:0]  START_LENGTH_RST  = 3'd1;
  localparam logic [4:0]  FRAME_LENGTH_RST  = 5'd11;
  localparam logic        KEY_MODE_RST      = 1'b1;
  localparam logic [15:0] HOLD_TIME_RST     = 16'd500;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_NOTHING = 3'd0,
    KIND_KNOWN   = 3'd1,
    KIND_LEARNED = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_STATUS  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REG_START_PATTERN = 3'd0,
    REG_START_LENGTH  = 3'd1,
    REG_FRAME_LENGTH  = 3'd2,
    REG_KEY_MODE      = 3'd3,
    REG_HOLD_TIME     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic in_ready;
    logic take_item;
    logic shift_frame;
    logic make_key;
    logic search_step;
    logic hit_commit;
    logic learn;
    logic drop_full;
    logic sweep_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    cmd_t in_cmd;
    logic hold_timed;
    logic frame_full;
    logic start_ok;
    logic search_hit;
    logic search_miss;
    logic table_full;
    logic sweep_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] ch_to_out(input logic [CH_W-1:0] ch);
    logic [CH_W+7:0] t;
    t = {8'b0, ch};
    return t[7:0];
  endfunction

  function automatic logic [CH_W-1:0] q_to_ch(input logic [7:0] q);
    logic [CH_W+7:0] t;
    t = {{CH_W{1'b0}}, q};
    return t[CH_W-1:0];
  endfunction

endpackage

>>> rtl/sidmap_if.sv
// Handshake channels of the mapper: request words in, result words out.
// No dependencies.
interface sidmap_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;
  logic [7:0] query_channel;
  modport source (output valid, cmd, rx_byte, query_channel, input ready);
  modport sink (input valid, cmd, rx_byte, query_channel, output ready);
endinterface

interface sidmap_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] channel;
  logic       active;
  modport source (output valid, result_kind, channel, active, input ready);
  modport sink (input valid, result_kind, channel, active, output ready);
endinterface

>>> rtl/serial_id_frame_channel_mapper_top.sv
// Serial frame to channel mapper, top level. One request word in, one result word out.
// A query, unused command or plain tick goes from idle to the result hand-off; a byte
// passes the start check, and a full frame with a good start searches the learned keys,
// one key entry read per cycle. A timed-hold tick sweeps all stamps (stamp RAM port).
// One word in flight at a time. Synchronous active-high reset clears config to defaults,
// the key table, all channels and the millisecond clock immediately; no clearing pass.
module serial_id_frame_channel_mapper_top import sidmap_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  sidmap_req_if.sink   req,
  sidmap_rsp_if.source rsp,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  // Command and status between the sequencer and the datapath.
  ctrl_cmd_t  ctl;
  dp_status_t sts;

  // Sequencer: idle, start check, key search, expiry sweep, result hand-off.
  sidmap_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  // Datapath: holds config, frame, key table and channel state and the registered result word.
  sidmap_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts)
  );
endmodule

>>> rtl/sidmap_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sidmap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/sidmap_ctrl.sv
// Sequencing state machine of the mapper.
// Depends on sidmap_pkg; drives the datapath through ctrl_cmd_t only.
module sidmap_ctrl import sidmap_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t sts,
  output ctrl_cmd_t  ctl
);
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SEARCH = 5'b00100,
    S_SWEEP  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        ctl.in_ready = 1'b1;
        if (sts.in_valid) begin
          ctl.take_item = 1'b1;
          case (sts.in_cmd)
            CMD_BYTE: state_next = S_CHECK;
            CMD_TICK: state_next = sts.hold_timed ? S_SWEEP : S_DONE;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_CHECK: begin
        if (!sts.frame_full) begin
          state_next = S_DONE;
        end else if (sts.start_ok) begin
          ctl.make_key = 1'b1;
          state_next = S_SEARCH;
        end else begin
          ctl.shift_frame = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SEARCH: begin
        ctl.search_step = 1'b1;
        if (sts.search_hit) begin
          ctl.hit_commit = 1'b1;
          state_next = S_DONE;
        end else if (sts.search_miss) begin
          if (sts.table_full) begin
            ctl.drop_full = 1'b1;
          end else begin
            ctl.learn = 1'b1;
          end
          state_next = S_DONE;
        end
      end
      S_SWEEP: begin
        ctl.sweep_step = 1'b1;
        if (sts.sweep_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

>>> rtl/sidmap_dp.sv
// Datapath: config registers, frame buffer, key table, channel state, result word.
// Depends on sidmap_pkg, sidmap_if and sidmap_ram.
module sidmap_dp import sidmap_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  sidmap_req_if.sink          req,
  sidmap_rsp_if.source        rsp,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  ctrl_cmd_t           ctl,
  output dp_status_t          sts
);
  logic [31:0] start_pattern;
  logic [2:0]  start_length;
  logic [4:0]  frame_size;
  logic        key_mode;
  logic [15:0] hold_time;

  logic [7:0]         frame_bytes [MAX_FRAME];
  logic [FL_W-1:0]    fill_count;
  logic [CNT_W-1:0]   keys_used;
  logic [CHANNELS-1:0] channel_on;
  logic [31:0]        clock_ms;
  logic [ENTRY_W-1:0] key_word;
  logic [CNT_W-1:0]   scan_idx;
  logic               pend;
  logic [CH_W-1:0]    pend_idx;
  kind_t              res_kind;
  logic [7:0]         res_channel;
  logic               res_active;

  logic [FL_W-1:0]    flen;
  logic [FIDX_W-1:0]  widx;
  logic [FL_W-1:0]    fill_next;
  logic               start_ok;
  logic [KEY_W-1:0]   key_bits;
  logic [ENTRY_W-1:0] new_entry;
  logic [ENTRY_W-1:0] key_rd;
  logic [31:0]        stamp_rd;
  logic [31:0]        elapsed;
  logic               match;
  logic               hold_zero;
  logic               take_byte;
  logic               take_tick;
  logic [CNT_W-1:0]   scan_lim;
  logic [CH_W-1:0]    commit_ch;
  logic               commit;
  logic [CH_W-1:0]    q_idx;
  logic               q_ok;

  assign hold_zero = (hold_time == 16'd0);
  assign take_byte = ctl.take_item && (cmd_t'(req.cmd) == CMD_BYTE);
  assign take_tick = ctl.take_item && (cmd_t'(req.cmd) == CMD_TICK);

  // Config registers; a frame length write also drops collected bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pattern <= START_PATTERN_RST;
      start_length  <= START_LENGTH_RST;
      frame_size    <= FRAME_LENGTH_RST;
      key_mode      <= KEY_MODE_RST;
      hold_time     <= HOLD_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_PATTERN: start_pattern <= cfg_data;
        REG_START_LENGTH:  start_length  <= cfg_data[2:0];
        REG_FRAME_LENGTH:  frame_size    <= cfg_data[4:0];
        REG_KEY_MODE:      key_mode      <= cfg_data[0];
        REG_HOLD_TIME:     hold_time     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_size == 5'd0) begin
      flen = FL_W'(1);
    end else if (32'(frame_size) > MAX_FRAME) begin
      flen = FL_W'(MAX_FRAME);
    end else begin
      flen = FL_W'(frame_size);
    end
  end

  always_comb begin
    if (32'(fill_count) >= MAX_FRAME) begin
      widx = '0;
      fill_next = FL_W'(1);
    end else begin
      widx = fill_count[FIDX_W-1:0];
      fill_next = fill_count + FL_W'(1);
    end
  end

  // Start pattern check over the leading bytes; bytes past the start length are not compared.
  always_comb begin
    logic [63:0] pat_ext;
    logic [7:0]  n;
    pat_ext = {32'b0, start_pattern};
    n = {5'b0, start_length};
    if (32'(n) > START_BYTES) n = 8'(START_BYTES);
    if (n > 8'(flen)) n = 8'(flen);
    start_ok = 1'b1;
    for (int k = 0; k < SB_N; k++) begin
      if (8'(k) < n && frame_bytes[k] != pat_ext[8*k +: 8]) start_ok = 1'b0;
    end
  end

  // Key: bytes past the frame length are zero so entries compare as whole words.
  always_comb begin
    logic [7:0] b;
    for (int j = 0; j < MAX_FRAME; j++) begin
      b = frame_bytes[j];
      if (!key_mode && (b < PRINT_LO || b > PRINT_HI)) b = DOT_BYTE;
      if (32'(j) >= 32'(flen)) b = 8'd0;
      key_bits[8*j +: 8] = b;
    end
  end
  assign new_entry = {key_mode, flen, key_bits};

  always_ff @(posedge clk) begin
    if (take_byte) begin
      frame_bytes[widx] <= req.rx_byte;
    end else if (ctl.shift_frame) begin
      for (int k = 0; k < MAX_FRAME - 1; k++) begin
        frame_bytes[k] <= frame_bytes[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cfg_we && cfg_index == REG_FRAME_LENGTH) begin
      fill_count <= '0;
    end else if (take_byte) begin
      fill_count <= fill_next;
    end else if (ctl.shift_frame) begin
      fill_count <= fill_count - FL_W'(1);
    end else if (ctl.make_key) begin
      fill_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.make_key) begin
      key_word <= new_entry;
    end
  end

  // Scan counter shared by the key search and the expiry sweep.
  assign scan_lim = ctl.sweep_step ? CNT_W'(CHANNELS) : keys_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      pend     <= 1'b0;
    end else if (ctl.take_item || ctl.make_key) begin
      scan_idx <= '0;
      pend     <= 1'b0;
    end else if (ctl.search_step || ctl.sweep_step) begin
      if (scan_idx < scan_lim) begin
        pend     <= 1'b1;
        scan_idx <= scan_idx + CNT_W'(1);
      end else begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.search_step || ctl.sweep_step) begin
      pend_idx <= scan_idx[CH_W-1:0];
    end
  end

  assign match     = pend && (key_rd == key_word);
  assign commit    = (ctl.hit_commit || ctl.learn) && !hold_zero;
  assign commit_ch = ctl.hit_commit ? pend_idx : keys_used[CH_W-1:0];
  assign elapsed   = clock_ms - stamp_rd;

  sidmap_ram #(.WIDTH(ENTRY_W), .DEPTH(CHANNELS)) u_key_ram (
    .clk   (clk),
    .we    (ctl.learn),
    .waddr (keys_used[CH_W-1:0]),
    .wdata (key_word),
    .raddr (scan_idx[CH_W-1:0]),
    .rdata (key_rd)
  );

  sidmap_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_stamp_ram (
    .clk   (clk),
    .we    (commit),
    .waddr (commit_ch),
    .wdata (clock_ms),
    .raddr (scan_idx[CH_W-1:0]),
    .rdata (stamp_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_used <= '0;
      clock_ms  <= '0;
    end else begin
      if (ctl.learn) keys_used <= keys_used + CNT_W'(1);
      if (take_tick) clock_ms <= clock_ms + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_on <= '0;
    end else if (take_tick && hold_zero) begin
      channel_on <= '0;
    end else if (commit) begin
      channel_on[commit_ch] <= 1'b1;
    end else if (ctl.sweep_step && pend && channel_on[pend_idx]
                 && elapsed >= {16'b0, hold_time}) begin
      channel_on[pend_idx] <= 1'b0;
    end
  end

  assign q_idx = q_to_ch(req.query_channel);
  assign q_ok  = ({24'b0, req.query_channel} < 32'(CHANNELS));

  always_ff @(posedge clk) begin
    if (ctl.take_item) begin
      if (cmd_t'(req.cmd) == CMD_QUERY) begin
        res_kind    <= KIND_STATUS;
        res_channel <= req.query_channel;
        res_active  <= q_ok && !hold_zero && channel_on[q_idx];
      end else begin
        res_kind    <= KIND_NOTHING;
        res_channel <= 8'd0;
        res_active  <= 1'b0;
      end
    end else if (ctl.hit_commit) begin
      res_kind    <= KIND_KNOWN;
      res_channel <= ch_to_out(pend_idx);
      res_active  <= 1'b1;
    end else if (ctl.learn) begin
      res_kind    <= KIND_LEARNED;
      res_channel <= ch_to_out(keys_used[CH_W-1:0]);
      res_active  <= 1'b1;
    end else if (ctl.drop_full) begin
      res_kind    <= KIND_FULL;
      res_channel <= 8'd0;
      res_active  <= 1'b0;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ctl.load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      rsp.result_kind <= res_kind;
      rsp.channel     <= res_channel;
      rsp.active      <= res_active;
    end
  end

  assign req.ready = ctl.in_ready;

  assign sts.in_valid    = req.valid;
  assign sts.in_cmd      = cmd_t'(req.cmd);
  assign sts.hold_timed  = (hold_time >= HOLD_TIMED);
  assign sts.frame_full  = (fill_count >= flen);
  assign sts.start_ok    = start_ok;
  assign sts.search_hit  = match;
  assign sts.search_miss = (keys_used == '0)
                           || (pend && !match && (CNT_W'(pend_idx) + CNT_W'(1) == keys_used));
  assign sts.table_full  = (keys_used == CNT_W'(CHANNELS));
  assign sts.sweep_done  = pend && (pend_idx == CH_W'(CHANNELS - 1));
  assign sts.out_free    = !rsp.valid || rsp.ready;
endmodule

>>> sim/tb.sv
// Testbench for serial_id_frame_channel_mapper_top: directed table, then random phases.
// Depends on rtl/sidmap_pkg.sv, rtl/sidmap_if.sv and the mapper RTL.
`timescale 1ns / 100ps

module tb;
  import sidmap_pkg::*;

  // One request word, with an optional hand-written expectation (directed rows only)
  typedef struct {
    cmd_t       cmd;
    logic [7:0] rx_byte;
    logic [7:0] query_channel;
    bit         typed;
    kind_t      t_kind;
    logic [7:0] t_channel;
    logic       t_active;
  } word_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] channel;
    logic       active;
  } outcome_t;

  typedef struct {
    logic [31:0] pattern;
    logic [2:0]  slen;
    logic [4:0]  flen;
    logic        mode;
    logic [15:0] hold;
  } setting_t;

  logic clk;
  logic rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  sidmap_req_if req_ch ();
  sidmap_rsp_if rsp_ch ();

  serial_id_frame_channel_mapper_top dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock: 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the mapper state, kept in step with every accepted word
  logic [31:0] mir_pattern;
  logic [2:0]  mir_slen;
  logic [4:0]  mir_flen;
  logic        mir_mode;
  logic [15:0] mir_hold;
  logic [7:0]  mir_frame [MAX_FRAME];
  int          mir_fill;
  logic [7:0]  mir_keys [CHANNELS][MAX_FRAME];
  bit          mir_valid [CHANNELS];
  int          mir_len [CHANNELS];
  bit          mir_kmode [CHANNELS];
  bit          mir_on [CHANNELS];
  logic [31:0] mir_stamp [CHANNELS];
  logic [31:0] mir_clock;

  word_t    offer_q[$];       // words waiting for the sender
  outcome_t pending_q[$];     // results owed by the block, oldest first
  word_t    on_wire;          // word currently offered on the request channel
  int       errors = 0;
  int       long_hold_req = 0;
  int       long_hold_seen = 0;
  logic [7:0] pool [6][MAX_FRAME];

  function automatic int frame_len_eff();
    int f;
    f = mir_flen;
    if (f == 0) f = 1;
    if (f > MAX_FRAME) f = MAX_FRAME;
    return f;
  endfunction

  function automatic int start_len_eff();
    int n;
    n = mir_slen;
    if (n > START_BYTES) n = START_BYTES;
    if (n > frame_len_eff()) n = frame_len_eff();
    return n;
  endfunction

  // Work out the result of one request word and advance the mirror
  function automatic outcome_t map_word(word_t w);
    outcome_t   r;
    int         fl, ch;
    bit         ok, hit, same;
    logic [7:0] key [MAX_FRAME];
    r = '{KIND_NOTHING, 8'd0, 1'b0};
    case (w.cmd)
      CMD_BYTE: begin
        fl = frame_len_eff();
        if (mir_fill >= MAX_FRAME) mir_fill = 0;
        mir_frame[mir_fill] = w.rx_byte;
        mir_fill++;
        if (mir_fill >= fl) begin
          ok = 1;
          for (int k = 0; k < start_len_eff(); k++)
            if (mir_frame[k] != mir_pattern[8*k +: 8]) ok = 0;
          if (!ok) begin
            // drop the oldest byte
            for (int k = 0; k < mir_fill - 1; k++) mir_frame[k] = mir_frame[k+1];
            mir_fill--;
          end else begin
            for (int k = 0; k < fl; k++) begin
              key[k] = mir_frame[k];
              if (!mir_mode && (key[k] < PRINT_LO || key[k] > PRINT_HI)) key[k] = DOT_BYTE;
            end
            mir_fill = 0;
            hit = 0;
            ch = 0;
            for (int c = 0; c < CHANNELS && !hit; c++) begin
              if (mir_valid[c] && mir_len[c] == fl && mir_kmode[c] == mir_mode) begin
                same = 1;
                for (int k = 0; k < fl; k++) if (mir_keys[c][k] != key[k]) same = 0;
                if (same) begin
                  hit = 1;
                  ch = c;
                end
              end
            end
            r.kind = KIND_KNOWN;
            if (!hit) begin
              for (int c = 0; c < CHANNELS && !hit; c++)
                if (!mir_valid[c]) begin
                  hit = 1;
                  ch = c;
                end
              if (!hit) return '{KIND_FULL, 8'd0, 1'b0};
              mir_valid[ch] = 1;
              mir_len[ch] = fl;
              mir_kmode[ch] = mir_mode;
              for (int k = 0; k < fl; k++) mir_keys[ch][k] = key[k];
              r.kind = KIND_LEARNED;
            end
            if (mir_hold != 0) begin
              mir_on[ch] = 1;
              mir_stamp[ch] = mir_clock;
            end
            r.channel = ch[7:0];
            r.active = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        mir_clock++;
        if (mir_hold == 0) begin
          foreach (mir_on[c]) mir_on[c] = 0;
        end else if (mir_hold >= HOLD_TIMED) begin
          foreach (mir_on[c])
            if (mir_on[c] && (mir_clock - mir_stamp[c]) >= {16'd0, mir_hold}) mir_on[c] = 0;
        end
      end
      CMD_QUERY: begin
        r.kind = KIND_STATUS;
        r.channel = w.query_channel;
        r.active = (mir_hold != 0) ? mir_on[w.query_channel] : 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Request sender: bursts of random length, random gaps between them
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    word_t w;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.cmd <= CMD_NONE;
      req_ch.rx_byte <= '0;
      req_ch.query_channel <= '0;
    end else if (req_ch.valid && !req_ch.ready) begin
      // hold the word until it is taken
    end else if (gap_left > 0) begin
      req_ch.valid <= 1'b0;
      gap_left--;
    end else if (offer_q.size() > 0) begin
      w = offer_q.pop_front();
      on_wire <= w;
      req_ch.valid <= 1'b1;
      req_ch.cmd <= w.cmd;
      req_ch.rx_byte <= w.rx_byte;
      req_ch.query_channel <= w.query_channel;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 20);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // Record what every accepted word owes
  always @(posedge clk) begin
    outcome_t p;
    if (!rst && req_ch.valid && req_ch.ready) begin
      p = map_word(on_wire);
      if (on_wire.typed) p = '{on_wire.t_kind, on_wire.t_channel, on_wire.t_active};
      pending_q.insert(pending_q.size(), p);
    end
  end

  // Result receiver: stall segments of different shapes, plus a long hold-off on request
  int seg_left = 0;
  int seg_shape = 0;
  int hold_left = 0;
  int rcount = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left--;
    end else if (long_hold_req != long_hold_seen) begin
      long_hold_seen = long_hold_req;
      hold_left = 400;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 200);
        seg_shape = $urandom_range(0, 2);
      end
      seg_left--;
      rcount++;
      case (seg_shape)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        default: rsp_ch.ready <= (rcount % 5 != 0) && (rcount % 7 != 3);
      endcase
    end
  end

  // Compare each taken result word with the oldest pending one
  always @(posedge clk) begin
    outcome_t p;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_q.size() == 0) begin
        report("unexpected result word kind", rsp_ch.result_kind, -1);
      end else begin
        p = pending_q.pop_front();
        if (rsp_ch.result_kind !== p.kind) report("result_kind", rsp_ch.result_kind, p.kind);
        if (rsp_ch.channel !== p.channel) report("channel", rsp_ch.channel, p.channel);
        if (rsp_ch.active !== p.active) report("active", rsp_ch.active, p.active);
      end
    end
  end

  task automatic add_word(cmd_t c, logic [7:0] b, logic [7:0] q);
    word_t w;
    w = '{c, b, q, 1'b0, KIND_NOTHING, 8'd0, 1'b0};
    offer_q.insert(offer_q.size(), w);
  endtask

  task automatic add_typed(cmd_t c, logic [7:0] b, logic [7:0] q,
                           kind_t k, logic [7:0] ch, logic act);
    word_t w;
    w = '{c, b, q, 1'b1, k, ch, act};
    offer_q.insert(offer_q.size(), w);
  endtask

  // Wait until every word is taken and every result has come, then let the block settle
  task automatic drain();
    while (offer_q.size() > 0 || req_ch.valid || pending_q.size() > 0) @(posedge clk);
    repeat (CHANNELS + 40) @(posedge clk);
  endtask

  // Write all five registers, one per cycle, while the block is idle
  task automatic apply_setting(setting_t s);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_START_PATTERN;
    cfg_data <= s.pattern;
    mir_pattern = s.pattern;
    @(posedge clk);
    cfg_index <= REG_START_LENGTH;
    cfg_data <= {29'd0, s.slen};
    mir_slen = s.slen;
    @(posedge clk);
    cfg_index <= REG_FRAME_LENGTH;
    cfg_data <= {27'd0, s.flen};
    mir_flen = s.flen;
    mir_fill = 0;
    @(posedge clk);
    cfg_index <= REG_KEY_MODE;
    cfg_data <= {31'd0, s.mode};
    mir_mode = s.mode;
    @(posedge clk);
    cfg_index <= REG_HOLD_TIME;
    cfg_data <= {16'd0, s.hold};
    mir_hold = s.hold;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Push a well-formed frame from the key pool, sometimes with one byte broken
  task automatic add_frame(bit broken);
    int   p, fl, ns, bad;
    logic [7:0] b;
    p = $urandom_range(0, 5);
    fl = frame_len_eff();
    ns = start_len_eff();
    bad = broken ? $urandom_range(0, fl - 1) : -1;
    for (int k = 0; k < fl; k++) begin
      b = (k < ns) ? mir_pattern[8*k +: 8] : pool[p][k];
      if (k == bad) b = b ^ (8'd1 << $urandom_range(0, 7));
      add_word(CMD_BYTE, b, 8'd0);
    end
  endtask

  // Random words: mostly frames, with ticks, queries, stray bytes and unused commands
  task automatic add_random(int count, int max_ticks);
    int n, r;
    foreach (pool[i, k]) pool[i][k] = 8'($urandom_range(0, 255));
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        add_frame($urandom_range(0, 9) == 0);
        n += frame_len_eff();
      end else if (r < 65) begin
        add_word(CMD_BYTE, 8'($urandom_range(0, 255)), 8'd0);
        n++;
      end else if (r < 80) begin
        repeat ($urandom_range(1, max_ticks)) begin
          add_word(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          n++;
        end
      end else if (r < 95) begin
        add_word(CMD_QUERY, 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7))
                                             : 8'($urandom_range(0, 255)));
        n++;
      end else begin
        add_word(CMD_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        n++;
      end
    end
  endtask

  initial begin
    logic [7:0] vals [CHANNELS];
    logic [7:0] t;
    int j;
    setting_t plan [6];

    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_START_PATTERN;
    cfg_data = '0;

    // Mirror reset state
    mir_pattern = START_PATTERN_RST;
    mir_slen = START_LENGTH_RST;
    mir_flen = FRAME_LENGTH_RST;
    mir_mode = KEY_MODE_RST;
    mir_hold = HOLD_TIME_RST;
    mir_fill = 0;
    mir_clock = '0;
    foreach (mir_valid[c]) begin
      mir_valid[c] = 0;
      mir_on[c] = 0;
      mir_len[c] = 0;
      mir_kmode[c] = 0;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table at reset settings: start byte 0x20, frame of 11 bytes, raw keys
    add_typed(CMD_QUERY, 8'h00, 8'd0, KIND_STATUS, 8'd0, 1'b0);
    add_typed(CMD_QUERY, 8'h00, 8'd255, KIND_STATUS, 8'd255, 1'b0);
    add_typed(CMD_NONE, 8'hFF, 8'hFF, KIND_NOTHING, 8'd0, 1'b0);
    // a stray byte is not a start byte: drop it
    add_typed(CMD_BYTE, 8'h00, 8'd0, KIND_NOTHING, 8'd0, 1'b0);
    add_word(CMD_BYTE, 8'h20, 8'd0);
    add_word(CMD_BYTE, 8'h00, 8'd0);
    add_word(CMD_BYTE, 8'hFF, 8'd0);
    for (int k = 0; k < 7; k++) add_word(CMD_BYTE, 8'(8'h41 + k), 8'd0);
    // first key after reset lands on channel zero
    add_typed(CMD_BYTE, 8'h7E, 8'd0, KIND_LEARNED, 8'd0, 1'b1);
    add_word(CMD_QUERY, 8'd0, 8'd0);
    add_word(CMD_TICK, 8'd0, 8'd0);
    add_word(CMD_BYTE, 8'h20, 8'd0);
    add_word(CMD_BYTE, 8'h00, 8'd0);
    add_word(CMD_BYTE, 8'hFF, 8'd0);
    for (int k = 0; k < 7; k++) add_word(CMD_BYTE, 8'(8'h41 + k), 8'd0);
    add_typed(CMD_BYTE, 8'h7E, 8'd0, KIND_KNOWN, 8'd0, 1'b1);
    drain();

    // Settings: timed, pulse, latched with clamped start length, oversized frame,
    // long timed hold, shortest latch
    plan[0] = '{32'h0000_0020, 3'd1, 5'd11, 1'b1, 16'd500};
    plan[1] = '{32'hFFFF_FFFF, 3'd4, 5'd16, 1'b0, 16'd0};
    plan[2] = '{32'hA5C3_0F5A, 3'd7, 5'd3, 1'b0, 16'd49};
    plan[3] = '{32'h1234_AA55, 3'd2, 5'd31, 1'b1, 16'd50};
    plan[4] = '{32'h0000_0041, 3'd1, 5'd5, 1'b0, 16'd65535};
    plan[5] = '{32'h00C0_FFEE, 3'd3, 5'd4, 1'b1, 16'd1};
    foreach (plan[i]) begin
      apply_setting(plan[i]);
      add_random(50, (plan[i].hold == HOLD_TIMED) ? 60 : 8);
      // hold off the receiver so the block backs up and stalls its input
      if (i == 0) long_hold_req++;
      drain();
    end

    // Fill the key table with one-byte frames, any start, then run past full
    apply_setting('{32'h0000_0000, 3'd0, 5'd0, 1'b1, 16'd60});
    foreach (vals[i]) vals[i] = 8'(i);
    for (int i = CHANNELS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = vals[i];
      vals[i] = vals[j];
      vals[j] = t;
    end
    foreach (vals[i]) add_word(CMD_BYTE, vals[i], 8'd0);
    add_random(40, 60);
    drain();

    if (pending_q.size() != 0) report("results outstanding", pending_q.size(), 0);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #80_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> serial_id_frame_channel_mapper_top.f
rtl/sidmap_pkg.sv
rtl/sidmap_if.sv
rtl/sidmap_ram.sv
rtl/sidmap_ctrl.sv
rtl/sidmap_dp.sv
rtl/serial_id_frame_channel_mapper_top.sv
sim/tb.sv
